### rtl/core/ape_pkg.sv
package ape_pkg;

    // Sector geometry and address width.
    localparam int unsigned WORDS_PER_SECTOR   = 256;
    localparam int unsigned WORD_CNT_W         = $clog2(WORDS_PER_SECTOR) + 1;
    localparam int unsigned ENTRIES_PER_SECTOR = WORDS_PER_SECTOR / 2;
    localparam int unsigned ENTRY_SHIFT        = $clog2(ENTRIES_PER_SECTOR);
    localparam int unsigned ENTRY_IDX_W        = ENTRY_SHIFT + 1;
    localparam int unsigned LBA_W              = 28;

    // Input opcodes.
    localparam logic [1:0] OP_READ_SECTORS = 2'd0;
    localparam logic [1:0] OP_READ_CLUSTER = 2'd1;
    localparam logic [1:0] OP_LOOKUP       = 2'd2;
    localparam logic [1:0] OP_DEVICE       = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DATA_REGION  = 2'd0;
    localparam logic [1:0] CFG_TABLE_REGION = 2'd1;
    localparam logic [1:0] CFG_CLUSTER_SECS = 2'd2;

    // Task file register offsets.
    localparam logic [2:0] REG_DATA    = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_LBA_LO  = 3'd3;
    localparam logic [2:0] REG_LBA_MID = 3'd4;
    localparam logic [2:0] REG_LBA_HI  = 3'd5;
    localparam logic [2:0] REG_DRIVE   = 3'd6;
    localparam logic [2:0] REG_CMD     = 3'd7;

    // Register values and status bits.
    localparam logic [7:0] DRIVE_LBA_MASTER = 8'hE0;
    localparam logic [7:0] CMD_READ_SECTORS = 8'h20;
    localparam logic [7:0] ONE_SECTOR       = 8'h01;
    localparam int unsigned ST_BSY_BIT      = 7;
    localparam int unsigned ST_DRQ_BIT      = 3;
    localparam int unsigned ST_ERR_BIT      = 0;
    localparam logic [LBA_W-1:0] END_OF_CHAIN = 28'h0FFFFFFF;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_STATUS,
        ACT_DATA
    } t_action;

    typedef struct packed {
        logic [LBA_W-1:0] data_region;
        logic [LBA_W-1:0] table_region;
        logic [7:0]       cluster_sectors;
    } t_cfg;

    typedef struct packed {
        t_action          action;
        logic [2:0]       bus_reg;
        logic [7:0]       write_value;
        logic [15:0]      word;
        logic             word_valid;
        logic [LBA_W-1:0] next_cluster;
        logic             cluster_valid;
        logic             done;
        logic             error;
    } t_result;

    // One decision: a single result, or the seven-beat command issue burst.
    typedef struct packed {
        logic             valid;
        logic             burst;
        logic [LBA_W-1:0] sector;
        t_result          res;
    } t_desc;

endpackage

### rtl/core/ata_pio_read_engine.sv
// ATA PIO sector read sequencer with 28-bit LBA addressing. Commands (read N
// sectors, read one cluster, look up the next cluster in the allocation table)
// and device read returns enter as beats on the slave stream; every bus access
// the host should perform, every delivered data word and every completion
// leaves as a beat on the master stream, with tlast on the final beat caused
// by each input beat. One input beat is taken per cycle while tready is high:
// the sequencer state and the next result are worked out in a single pass and
// land in the output register. Most input beats give at most one result and so
// flow at one per cycle while the master side is ready. A status read that
// shows BSY clear gives seven results (six task file writes and the first DRQ
// poll), sent one per cycle while the master side is ready; the slave side is
// held and the next beat enters as the seventh leaves. tready on the slave
// side rises in the cycle the output register is empty or its final beat is
// being taken. Configuration writes are always accepted and must be made only
// while no command is running.
module ata_pio_read_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: commands and device returns.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata, lowest bit up: start_sector[27:0], sector_total[35:28],
    // cluster_number[63:36], device_value[79:64]
    input  logic [79:0] i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]  i_s_tuser,
    // Master stream: bus actions and results.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata, lowest bit up: bus_register[2:0], bus_write_value[10:3],
    // sector_word[26:11], word_valid[27], next_cluster[55:28],
    // cluster_valid[56], command_done[57], command_error[58], zero[63:59]
    output logic [63:0] o_m_tdata,
    // tuser: bus_action[1:0]
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [27:0] i_cfg_data
);
    import ape_pkg::*;

    t_cfg    cfg;
    t_desc   desc;
    t_result res;
    logic    take;
    logic    accept;

    // Registers are plain flops, so a write can land in any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = take;
    assign accept      = i_s_tvalid && take;

    ape_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Sequencer state and the decision for the current beat.
    ape_decide u_decide (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_opcode         (i_s_tuser),
        .i_start_sector   (i_s_tdata[27:0]),
        .i_sector_total   (i_s_tdata[35:28]),
        .i_cluster_number (i_s_tdata[63:36]),
        .i_device_value   (i_s_tdata[79:64]),
        .i_cfg            (cfg),
        .o_desc           (desc)
    );

    // Output register; expands the command issue burst into single beats.
    ape_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && desc.valid),
        .i_desc  (desc),
        .i_ready (i_m_tready),
        .o_take  (take),
        .o_valid (o_m_tvalid),
        .o_last  (o_m_tlast),
        .o_res   (res)
    );

    assign o_m_tuser = res.action;
    assign o_m_tdata = {5'd0, res.error, res.done, res.cluster_valid, res.next_cluster,
                        res.word_valid, res.word, res.write_value, res.bus_reg};

endmodule

### rtl/core/ape_cfg.sv
module ape_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [1:0]                    i_index,
    input  logic [ape_pkg::LBA_W-1:0]     i_data,
    output ape_pkg::t_cfg                 o_cfg
);
    import ape_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_region     <= '0;
            r_cfg.table_region    <= '0;
            r_cfg.cluster_sectors <= 8'd1;
        end else if (i_wr) begin
            case (i_index)
                CFG_DATA_REGION:  r_cfg.data_region     <= i_data;
                CFG_TABLE_REGION: r_cfg.table_region    <= i_data;
                CFG_CLUSTER_SECS: r_cfg.cluster_sectors <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/ape_decide.sv
module ape_decide (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [1:0]                    i_opcode,
    input  logic [ape_pkg::LBA_W-1:0]     i_start_sector,
    input  logic [7:0]                    i_sector_total,
    input  logic [ape_pkg::LBA_W-1:0]     i_cluster_number,
    input  logic [15:0]                   i_device_value,
    input  ape_pkg::t_cfg                 i_cfg,
    output ape_pkg::t_desc                o_desc
);
    import ape_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_BUSY, PH_DRQ, PH_DATA} t_phase;
    typedef enum logic [1:0] {KIND_SECTORS, KIND_CLUSTER, KIND_LOOKUP} t_kind;

    t_phase                  r_phase,  n_phase;
    t_kind                   r_kind,   n_kind;
    logic [LBA_W-1:0]        r_sector, n_sector;
    logic [7:0]              r_secs,   n_secs;
    logic [WORD_CNT_W-1:0]   r_words,  n_words;
    logic [ENTRY_IDX_W-1:0]  r_entry,  n_entry;
    logic [15:0]             r_low,    n_low;
    logic [15:0]             r_high,   n_high;

    logic [LBA_W-1:0]        cl_m2;
    logic [LBA_W+7:0]        cl_prod;
    logic [LBA_W-1:0]        cl_lba;
    logic [WORD_CNT_W-1:0]   word_idx;
    logic [WORD_CNT_W-1:0]   words_dec;
    logic [7:0]              secs_dec;
    logic [7:0]              status;
    t_desc                   desc;

    // Cluster to LBA: a subtract of two, one 28 x 8 multiply and an add, wrapping at 28 bits.
    assign cl_m2   = i_cluster_number - LBA_W'(2);
    assign cl_prod = (LBA_W+8)'(cl_m2) * (LBA_W+8)'(i_cfg.cluster_sectors);
    assign cl_lba  = i_cfg.data_region + cl_prod[LBA_W-1:0];

    assign word_idx  = WORD_CNT_W'(WORDS_PER_SECTOR) - r_words;
    assign words_dec = r_words - WORD_CNT_W'(1);
    assign secs_dec  = r_secs - 8'd1;
    assign status    = i_device_value[7:0];

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_sector = r_sector;
        n_secs   = r_secs;
        n_words  = r_words;
        n_entry  = r_entry;
        n_low    = r_low;
        n_high   = r_high;
        desc     = '0;

        if (i_opcode != OP_DEVICE) begin
            if (r_phase == PH_IDLE) begin
                desc.valid = 1'b1;
                case (i_opcode)
                    OP_READ_SECTORS: begin
                        if (i_sector_total == 8'd0) begin
                            desc.res.done = 1'b1;
                        end else begin
                            n_sector = i_start_sector;
                            n_secs   = i_sector_total;
                            n_kind   = KIND_SECTORS;
                            n_phase  = PH_BUSY;
                            desc.res.action  = ACT_STATUS;
                            desc.res.bus_reg = REG_CMD;
                        end
                    end
                    OP_READ_CLUSTER: begin
                        if (i_cfg.cluster_sectors == 8'd0) begin
                            desc.res.done = 1'b1;
                        end else begin
                            n_sector = cl_lba;
                            n_secs   = i_cfg.cluster_sectors;
                            n_kind   = KIND_CLUSTER;
                            n_phase  = PH_BUSY;
                            desc.res.action  = ACT_STATUS;
                            desc.res.bus_reg = REG_CMD;
                        end
                    end
                    default: begin
                        // Next-cluster lookup: one table sector holds 128 entries.
                        n_sector = i_cfg.table_region + (i_cluster_number >> ENTRY_SHIFT);
                        n_entry  = {i_cluster_number[ENTRY_SHIFT-1:0], 1'b0};
                        n_low    = '0;
                        n_high   = '0;
                        n_secs   = 8'd1;
                        n_kind   = KIND_LOOKUP;
                        n_phase  = PH_BUSY;
                        desc.res.action  = ACT_STATUS;
                        desc.res.bus_reg = REG_CMD;
                    end
                endcase
            end
        end else begin
            case (r_phase)
                PH_BUSY: begin
                    desc.valid = 1'b1;
                    if (status[ST_BSY_BIT]) begin
                        desc.res.action  = ACT_STATUS;
                        desc.res.bus_reg = REG_CMD;
                    end else begin
                        desc.burst  = 1'b1;
                        desc.sector = r_sector;
                        n_phase     = PH_DRQ;
                    end
                end
                PH_DRQ: begin
                    desc.valid = 1'b1;
                    if (status[ST_ERR_BIT]) begin
                        desc.res.done  = 1'b1;
                        desc.res.error = 1'b1;
                        if (r_kind == KIND_LOOKUP) begin
                            desc.res.next_cluster  = END_OF_CHAIN;
                            desc.res.cluster_valid = 1'b1;
                        end
                        n_phase = PH_IDLE;
                    end else if (status[ST_DRQ_BIT]) begin
                        n_words         = WORD_CNT_W'(WORDS_PER_SECTOR);
                        desc.res.action = ACT_DATA;
                        n_phase         = PH_DATA;
                    end else begin
                        desc.res.action  = ACT_STATUS;
                        desc.res.bus_reg = REG_CMD;
                    end
                end
                PH_DATA: begin
                    desc.valid = 1'b1;
                    if (r_kind == KIND_LOOKUP) begin
                        if (word_idx == WORD_CNT_W'(r_entry)) begin
                            n_low = i_device_value;
                        end
                        if (word_idx == WORD_CNT_W'(r_entry) + WORD_CNT_W'(1)) begin
                            n_high = i_device_value;
                        end
                    end else begin
                        desc.res.word       = i_device_value;
                        desc.res.word_valid = 1'b1;
                    end
                    n_words = words_dec;
                    if (words_dec != '0) begin
                        desc.res.action = ACT_DATA;
                    end else begin
                        n_secs = secs_dec;
                        if (secs_dec != 8'd0) begin
                            n_sector         = r_sector + LBA_W'(1);
                            n_phase          = PH_BUSY;
                            desc.res.action  = ACT_STATUS;
                            desc.res.bus_reg = REG_CMD;
                        end else begin
                            desc.res.done = 1'b1;
                            if (r_kind == KIND_LOOKUP) begin
                                desc.res.next_cluster  = {n_high[LBA_W-17:0], n_low};
                                desc.res.cluster_valid = 1'b1;
                            end
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_kind   <= KIND_SECTORS;
            r_sector <= '0;
            r_secs   <= '0;
            r_words  <= '0;
            r_entry  <= '0;
            r_low    <= '0;
            r_high   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_sector <= n_sector;
            r_secs   <= n_secs;
            r_words  <= n_words;
            r_entry  <= n_entry;
            r_low    <= n_low;
            r_high   <= n_high;
        end
    end

    assign o_desc = desc;

    // A running command always has at least the current sector still to go.
    a_secs_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_IDLE |-> r_secs != 8'd0)
        else $error("sector count is zero while a command runs");

    // While reading data there is always at least one word outstanding.
    a_words_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_words != '0)
        else $error("word count is zero in the data phase");

endmodule

### rtl/core/ape_emit.sv
module ape_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  ape_pkg::t_desc        i_desc,
    input  logic                  i_ready,
    output logic                  o_take,
    output logic                  o_valid,
    output logic                  o_last,
    output ape_pkg::t_result      o_res
);
    import ape_pkg::*;

    localparam logic [2:0] BURST_LAST = 3'd6;

    logic             r_valid;
    logic             r_burst;
    logic [2:0]       r_count;
    logic [LBA_W-1:0] r_sector;
    t_result          r_res;
    t_result          burst_res;

    // Command issue burst: drive/head, count, three LBA bytes, READ, then status poll.
    always_comb begin
        burst_res        = '0;
        burst_res.action = ACT_WRITE;
        case (r_count)
            3'd0: begin
                burst_res.bus_reg     = REG_DRIVE;
                burst_res.write_value = DRIVE_LBA_MASTER | {4'd0, r_sector[27:24]};
            end
            3'd1: begin
                burst_res.bus_reg     = REG_COUNT;
                burst_res.write_value = ONE_SECTOR;
            end
            3'd2: begin
                burst_res.bus_reg     = REG_LBA_LO;
                burst_res.write_value = r_sector[7:0];
            end
            3'd3: begin
                burst_res.bus_reg     = REG_LBA_MID;
                burst_res.write_value = r_sector[15:8];
            end
            3'd4: begin
                burst_res.bus_reg     = REG_LBA_HI;
                burst_res.write_value = r_sector[23:16];
            end
            3'd5: begin
                burst_res.bus_reg     = REG_CMD;
                burst_res.write_value = CMD_READ_SECTORS;
            end
            default: begin
                burst_res.action  = ACT_STATUS;
                burst_res.bus_reg = REG_CMD;
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_last  = !r_burst || (r_count == BURST_LAST);
    assign o_res   = r_burst ? burst_res : r_res;
    assign o_take  = !r_valid || (i_ready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_burst  <= 1'b0;
            r_count  <= '0;
            r_sector <= '0;
            r_res    <= '0;
        end else begin
            if (r_valid && i_ready) begin
                if (o_last) begin
                    r_valid <= 1'b0;
                end else begin
                    r_count <= r_count + 3'd1;
                end
            end
            if (i_load) begin
                r_valid  <= 1'b1;
                r_burst  <= i_desc.burst;
                r_count  <= '0;
                r_sector <= i_desc.sector;
                r_res    <= i_desc.res;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_count <= BURST_LAST)
        else $error("burst beat counter out of range");

    a_single_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_burst |-> r_count == '0)
        else $error("single result with a non-zero beat count");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_count))
        else $error("burst advanced while the output was stalled");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_take)
        else $error("new decision loaded over an unfinished result");

endmodule
